// ===== rtl/fed_pkg.sv =====
package fed_pkg;

    localparam logic [15:0] CH_TAB        = 16'h0009;
    localparam logic [15:0] CH_CR         = 16'h000D;
    localparam logic [15:0] CH_SPACE      = 16'h0020;
    localparam logic [15:0] CH_BANG       = 16'h0021;
    localparam logic [15:0] CH_DOLLAR     = 16'h0024;
    localparam logic [15:0] CH_PERCENT    = 16'h0025;
    localparam logic [15:0] CH_PLUS       = 16'h002B;
    localparam logic [15:0] CH_MINUS      = 16'h002D;
    localparam logic [15:0] CH_ZERO       = 16'h0030;
    localparam logic [15:0] CH_NINE       = 16'h0039;
    localparam logic [15:0] CH_UPPER_A    = 16'h0041;
    localparam logic [15:0] CH_UPPER_F    = 16'h0046;
    localparam logic [15:0] CH_UPPER_X    = 16'h0058;
    localparam logic [15:0] CH_UNDERSCORE = 16'h005F;
    localparam logic [15:0] CH_LOWER_A    = 16'h0061;
    localparam logic [15:0] CH_LOWER_F    = 16'h0066;
    localparam logic [15:0] CH_LOWER_X    = 16'h0078;
    localparam logic [15:0] CH_LOWER_Z    = 16'h007A;
    localparam logic [15:0] CASE_OFFSET   = 16'd32;

    localparam logic [2:0] LEN_PCT = 3'd2;
    localparam logic [2:0] LEN_DOL = 3'd4;

    typedef struct packed {
        logic [15:0] ch;
        logic        has_char;
        logic        eos;
    } fed_result_t;

    // up to two results per accepted item, r[0] first
    typedef struct packed {
        logic [1:0]            n;
        fed_result_t [1:0]     r;
    } fed_push_t;

    function automatic logic is_blank(input logic [15:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // {valid, value}
    function automatic logic [4:0] hex_digit(input logic [15:0] c);
        logic [15:0] d;
        d = '0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = c - CH_ZERO;
            return {1'b1, d[3:0]};
        end
        if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
            d = c - CH_LOWER_A + 16'd10;
            return {1'b1, d[3:0]};
        end
        if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
            d = c - CH_UPPER_A + 16'd10;
            return {1'b1, d[3:0]};
        end
        return 5'b0_0000;
    endfunction

    // strtol-style base 16 read over the first len characters of s
    function automatic logic [15:0] parse_hex(input logic [3:0][15:0] s, input logic [2:0] len);
        logic [2:0]  i;
        logic [2:0]  j;
        logic        neg;
        logic        stop;
        logic [15:0] v;
        logic [15:0] cur;
        logic [15:0] nxt;
        logic [4:0]  hd;
        i    = '0;
        neg  = 1'b0;
        stop = 1'b0;
        v    = '0;
        for (int k = 0; k < 4; k++) begin
            if (i == 3'(k) && 3'(k) < len && is_blank(s[k])) begin
                i = 3'(k + 1);
            end
        end
        cur = (i < len) ? s[i[1:0]] : '0;
        if (i < len && (cur == CH_PLUS || cur == CH_MINUS)) begin
            neg = (cur == CH_MINUS);
            i   = i + 3'd1;
        end
        j   = i + 3'd1;
        cur = (i < len) ? s[i[1:0]] : '0;
        nxt = (j < len) ? s[j[1:0]] : '0;
        if (j < len && cur == CH_ZERO && (nxt == CH_LOWER_X || nxt == CH_UPPER_X)) begin
            i = i + 3'd2;
        end
        for (int k = 0; k < 4; k++) begin
            if (!stop && 3'(k) >= i && 3'(k) < len) begin
                hd = hex_digit(s[k]);
                if (!hd[4]) begin
                    stop = 1'b1;
                end else begin
                    v = {v[11:0], hd[3:0]};
                end
            end
        end
        if (neg) begin
            v = 16'd0 - v;
        end
        return v;
    endfunction

endpackage

// ===== rtl/fed_result_fifo.sv =====
module fed_result_fifo
    import fed_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  fed_push_t   push,
    output logic        space_ok,
    output logic        out_valid,
    input  logic        out_ready,
    output fed_result_t head
);

    localparam int DEPTH = 4;

    fed_result_t [DEPTH-1:0] q_reg;
    fed_result_t [DEPTH-1:0] q_next;
    logic [2:0]              cnt_reg;
    logic [2:0]              cnt_next;
    logic [1:0]              base;
    logic                    pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (cnt_reg != 3'd0);
    assign head      = q_reg[0];
    // room for the worst case of two results per item
    assign space_ok  = (cnt_reg <= 3'd2);

    always_comb begin
        q_next   = q_reg;
        cnt_next = cnt_reg;
        if (pop) begin
            for (int k = 0; k < DEPTH - 1; k++) begin
                q_next[k] = q_reg[k+1];
            end
            cnt_next = cnt_reg - 3'd1;
        end
        base = cnt_next[1:0];
        if (push.n != 2'd0) begin
            q_next[base] = push.r[0];
        end
        if (push.n == 2'd2) begin
            q_next[base + 2'd1] = push.r[1];
        end
        cnt_next = cnt_next + 3'(push.n);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        q_reg <= q_next;
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 3'd4)
        else $error("result queue overfilled");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push.n != 2'd0 |-> cnt_reg <= 3'd2)
        else $error("push without room");

    a_cnt_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.n == 2'd1 && !pop) |=> cnt_reg == $past(cnt_reg) + 3'd1)
        else $error("queue count lost a push");

endmodule

// ===== rtl/filename_escape_decoder.sv =====
// Decodes an escaped file-name stream, one 16-bit character per input item on s_.
// '_' gives a space, '!' before a lowercase letter gives the uppercase letter,
// '%' with two and '$' with four following characters give one character read as
// base 16 (blanks, sign and 0x prefix allowed). Each input item yields zero, one or
// two result items on m_; the last input always ends with a result marked m_tlast,
// with m_tuser low when it carries no character. The decode of one item is a single
// pass of logic into a four-entry result queue, so one item per cycle is accepted
// as long as the queue holds two items or fewer; items that expand to two results
// are limited by the one-per-cycle drain.
module filename_escape_decoder
    import fed_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // char_in
    input  logic        s_tlast,   // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // char_out
    output logic        m_tuser,   // has_char
    output logic        m_tlast    // end_of_string
);

    typedef enum logic [2:0] {
        PH_IDLE, PH_BANG, PH_PCT1, PH_PCT2, PH_DOL1, PH_DOL2, PH_DOL3, PH_DOL4
    } phase_t;

    typedef struct packed {
        logic        emit;
        logic [15:0] ch;
        phase_t      phase;
    } idle_t;

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [47:0] buf_reg;
    logic [47:0] buf_next;
    logic        accept;
    fed_push_t   push;
    fed_result_t head;
    fed_result_t [1:0] res;
    logic [1:0]  cnt;
    idle_t       idl;

    function automatic idle_t idle_char(input logic [15:0] c);
        idle_t r;
        r.emit  = 1'b0;
        r.ch    = c;
        r.phase = PH_IDLE;
        if (c == CH_UNDERSCORE) begin
            r.emit = 1'b1;
            r.ch   = CH_SPACE;
        end else if (c == CH_BANG) begin
            r.phase = PH_BANG;
        end else if (c == CH_PERCENT) begin
            r.phase = PH_PCT1;
        end else if (c == CH_DOLLAR) begin
            r.phase = PH_DOL1;
        end else begin
            r.emit = 1'b1;
        end
        return r;
    endfunction

    assign accept = s_tvalid && s_tready;

    always_comb begin
        phase_next = phase_reg;
        buf_next   = buf_reg;
        res        = '0;
        cnt        = 2'd0;
        idl        = idle_char(s_tdata);
        unique case (phase_reg)
            PH_IDLE: begin
                phase_next = idl.phase;
                if (idl.emit) begin
                    res[0] = '{ch: idl.ch, has_char: 1'b1, eos: 1'b0};
                    cnt    = 2'd1;
                end
            end
            PH_BANG: begin
                if (s_tdata >= CH_LOWER_A && s_tdata <= CH_LOWER_Z) begin
                    phase_next = PH_IDLE;
                    res[0]     = '{ch: s_tdata - CASE_OFFSET, has_char: 1'b1, eos: 1'b0};
                    cnt        = 2'd1;
                end else begin
                    // the held '!' comes out, then the character decodes normally
                    phase_next = idl.phase;
                    res[0]     = '{ch: CH_BANG, has_char: 1'b1, eos: 1'b0};
                    res[1]     = '{ch: idl.ch, has_char: 1'b1, eos: 1'b0};
                    cnt        = idl.emit ? 2'd2 : 2'd1;
                end
            end
            PH_PCT1: begin
                buf_next[15:0] = s_tdata;
                phase_next     = PH_PCT2;
            end
            PH_DOL1: begin
                buf_next[15:0] = s_tdata;
                phase_next     = PH_DOL2;
            end
            PH_DOL2: begin
                buf_next[31:16] = s_tdata;
                phase_next      = PH_DOL3;
            end
            PH_DOL3: begin
                buf_next[47:32] = s_tdata;
                phase_next      = PH_DOL4;
            end
            PH_PCT2: begin
                res[0] = '{ch: parse_hex({32'h0, s_tdata, buf_reg[15:0]}, LEN_PCT),
                           has_char: 1'b1, eos: 1'b0};
                cnt        = 2'd1;
                phase_next = PH_IDLE;
            end
            PH_DOL4: begin
                res[0] = '{ch: parse_hex({s_tdata, buf_reg}, LEN_DOL),
                           has_char: 1'b1, eos: 1'b0};
                cnt        = 2'd1;
                phase_next = PH_IDLE;
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase

        if (s_tlast) begin
            // a '!' left pending at the end stands for itself
            if (phase_next == PH_BANG) begin
                res[cnt[0]] = '{ch: CH_BANG, has_char: 1'b1, eos: 1'b0};
                cnt         = cnt + 2'd1;
            end
            phase_next = PH_IDLE;
            if (cnt == 2'd0) begin
                res[0] = '{ch: 16'h0000, has_char: 1'b0, eos: 1'b1};
                cnt    = 2'd1;
            end else begin
                res[cnt[0] - 1'b1].eos = 1'b1;
            end
        end

        push.r = res;
        push.n = accept ? cnt : 2'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
        end else if (accept) begin
            phase_reg <= phase_next;
        end
        if (accept) begin
            buf_reg <= buf_next;
        end
    end

    fed_result_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .space_ok  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .head      (head)
    );

    assign m_tdata = head.ch;
    assign m_tuser = head.has_char;
    assign m_tlast = head.eos;

    a_last_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tlast) |=> phase_reg == PH_IDLE)
        else $error("escape state survived end of string");

    a_last_has_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tlast) |-> push.n != 2'd0)
        else $error("last item produced no result");

    a_push_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        push.n != 2'd3)
        else $error("more than two results for one item");

    a_empty_no_char: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tlast && m_tdata == 16'h0000))
        else $error("empty result not at end of string");

endmodule
